### src/binomial_3x3_blur_macros.svh
// Assertion macros shared by the binomial 3x3 blur RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef BINOMIAL_3X3_BLUR_MACROS_SVH
`define BINOMIAL_3X3_BLUR_MACROS_SVH

// Property must hold at every edge out of reset.
`define BIN3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define BIN3_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define BIN3_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### src/bin3_pkg.sv
// Shared constants and types for the binomial 3x3 blur.
// No dependencies; used by bin3_emit and binomial_3x3_blur.
`default_nettype none

package bin3_pkg;

  // Fixed field and register widths
  localparam int RowW       = 12;
  localparam int WidthCfgW  = 11;
  localparam int HeightCfgW = 13;
  localparam int CfgDataW   = 13;
  localparam int CfgIdxW    = 2;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Frame size limits and reset sizes
  localparam int MinSize     = 3;
  localparam int MaxHeight   = 4096;
  localparam int WidthReset  = 128;
  localparam int HeightReset = 64;

  // Kernel normalization: weights sum to 16, round half up
  localparam int RoundBias = 8;
  localparam int NormShift = 4;

  // Slots of the per-item result mask, in emission order
  localparam int RES_FILT = 0;  // pixel (r-1, c-1)
  localparam int RES_EDGE = 1;  // right border pixel (r-1, c)
  localparam int RES_LAST = 2;  // last-row pixel (r, c)
  localparam int ResN     = 3;

  // Position flags of an item, worked out when it is accepted
  typedef struct packed {
    logic delayed;   // row and column both nonzero: an upper-left pixel is done
    logic border;    // that pixel lies on the top row or left column
    logic last_col;
    logic last_row;
  } bin3_flags_t;

endpackage

`default_nettype wire

### src/bin3_line_mem.sv
// Line buffer memory: both previous rows side by side in one word per column.
// One write and one registered read port, with a bypass for same-address access.
`default_nettype none

module bin3_line_mem #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] byp_data_q;
  logic              byp_q;

  // Storage array and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem[raddr_i];
      byp_data_q <= wdata_i;
    end
  end

  // Read of the entry written in the same cycle returns the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (re_i) begin
      byp_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

### src/bin3_emit.sv
// Result stage: horizontal kernel sum and sequencing of up to three results per item.
// Depends on bin3_pkg and binomial_3x3_blur_macros.svh.
`default_nettype none
`include "binomial_3x3_blur_macros.svh"

module bin3_emit #(
  parameter int SAMPLE_BITS = 16,
  parameter int COL_W       = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // item bundle from the window stage
  input  wire logic                         bundle_valid_i,
  output logic                              bundle_ready_o,
  input  wire bin3_pkg::bin3_flags_t        flags_i,
  input  wire logic [bin3_pkg::RowW-1:0]    row_i,
  input  wire logic [COL_W-1:0]             col_i,
  input  wire logic [SAMPLE_BITS+1:0]       vsum_c2_i,
  input  wire logic [SAMPLE_BITS+1:0]       vsum_c1_i,
  input  wire logic [SAMPLE_BITS+1:0]       vsum_c0_i,
  input  wire logic [SAMPLE_BITS-1:0]       center_i,
  input  wire logic [SAMPLE_BITS-1:0]       mid_i,
  input  wire logic [SAMPLE_BITS-1:0]       bot_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [bin3_pkg::RowW-1:0]    out_row_o,
  output logic      [COL_W-1:0]             out_col_o,
  output logic      [SAMPLE_BITS-1:0]       value_o,
  output logic                              frame_end_o
);

  localparam int SumW = SAMPLE_BITS + 2;
  localparam int AccW = SAMPLE_BITS + 4;

  // Held item
  logic [bin3_pkg::ResN-1:0] pend_q, pend_d, mask_new, sel;
  bin3_pkg::bin3_flags_t     flags_q;
  logic [bin3_pkg::RowW-1:0] row_q;
  logic [COL_W-1:0]          col_q;
  logic [SumW-1:0]           vs2_q, vs1_q, vs0_q;
  logic [SAMPLE_BITS-1:0]    center_q, mid_q, bot_q;

  // Output register
  logic                      out_valid_q;
  logic [bin3_pkg::RowW-1:0] out_row_q;
  logic [COL_W-1:0]          out_col_q;
  logic [SAMPLE_BITS-1:0]    value_q;
  logic                      frame_end_q;

  logic                      out_free, take, single, load;
  logic [AccW-1:0]           hsum;
  logic [SAMPLE_BITS-1:0]    filt, res_value;
  logic [bin3_pkg::RowW-1:0] res_row;
  logic [COL_W-1:0]          res_col;
  logic                      res_fend;

  // Handshake between held item and output register
  assign out_free       = !out_valid_q || out_ready_i;
  assign take           = out_free && (pend_q != '0);
  assign single         = (pend_q & (pend_q - 1'b1)) == '0;
  assign bundle_ready_o = (pend_q == '0) || (out_free && single);
  assign load           = bundle_valid_i && bundle_ready_o;

  // Results an incoming item produces
  always_comb begin
    mask_new = '0;
    mask_new[bin3_pkg::RES_FILT] = flags_i.delayed;
    mask_new[bin3_pkg::RES_EDGE] = flags_i.delayed && flags_i.last_col;
    mask_new[bin3_pkg::RES_LAST] = flags_i.last_row;
  end

  // Lowest pending slot goes first
  assign sel = pend_q & (~pend_q + 1'b1);

  always_comb begin
    pend_d = take ? (pend_q & ~sel) : pend_q;
    if (load) begin
      pend_d = mask_new;
    end
  end

  // Horizontal pass over the three column sums, weights 1,2,1
  assign hsum = AccW'(vs2_q) + (AccW'(vs1_q) << 1) + AccW'(vs0_q)
              + AccW'(bin3_pkg::RoundBias);
  assign filt = hsum[AccW-1:bin3_pkg::NormShift];

  // Field select for the slot being sent
  always_comb begin
    res_row   = row_q - 1'b1;
    res_col   = col_q;
    res_value = mid_q;
    res_fend  = 1'b0;
    if (sel[bin3_pkg::RES_FILT]) begin
      res_col   = col_q - 1'b1;
      res_value = flags_q.border ? center_q : filt;
    end else if (sel[bin3_pkg::RES_LAST]) begin
      res_row   = row_q;
      res_value = bot_q;
      res_fend  = flags_q.last_col;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_free) begin
        out_valid_q <= take;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      flags_q  <= flags_i;
      row_q    <= row_i;
      col_q    <= col_i;
      vs2_q    <= vsum_c2_i;
      vs1_q    <= vsum_c1_i;
      vs0_q    <= vsum_c0_i;
      center_q <= center_i;
      mid_q    <= mid_i;
      bot_q    <= bot_i;
    end
    if (take) begin
      out_row_q   <= res_row;
      out_col_q   <= res_col;
      value_q     <= res_value;
      frame_end_q <= res_fend;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign value_o     = value_q;
  assign frame_end_o = frame_end_q;

  `BIN3_ASSERT_IMPLY(a_no_load_multi, $countones(pend_q) > 1, !bundle_ready_o, "item overwritten with results pending")
  `BIN3_ASSERT_IMPLY(a_out_from_pend, $rose(out_valid_q), $past(pend_q != '0), "result shown with nothing pending")
  `BIN3_ASSERT_NEXT(a_out_held, out_valid_q && !out_ready_i, out_valid_q, "waiting result dropped")

endmodule

`default_nettype wire

### src/binomial_3x3_blur.sv
// Binomial 3x3 blur of a raster height map, one sample per item in and out.
// Depends on bin3_pkg, bin3_line_mem, bin3_emit and binomial_3x3_blur_macros.svh.
//
// Takes one sample per clock while the input is not held. Each item reads one
// word of a single line memory (rows r-1 and r-2 side by side at the column) and
// writes the updated word back as the item leaves the window stage, so the
// memory port pair sets the rate of one item per cycle. Results follow the input
// by one row and one column; an item at the end of a row or in the last row
// gives up to three results, and since the result port moves one per cycle the
// input is held there until all but the last are sent. An item passes the
// window stage and held item registers before its first result is registered.
// Interior pixels are (sum of weights 1,2,1 / 2,4,2 / 1,2,1 + 8) >> 4, border
// pixels pass through, and last-row pixels are sent as they arrive. A write to
// either size register restarts the frame at row 0, column 0; write registers
// only while the block is idle. The line memory is not cleared at reset.
`default_nettype none
`include "binomial_3x3_blur_macros.svh"

module binomial_3x3_blur #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input items
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]              sample_i,
  // result items
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [bin3_pkg::RowW-1:0]           out_row_o,
  output logic      [$clog2(MAX_WIDTH)-1:0]        out_col_o,
  output logic      [SAMPLE_BITS-1:0]              value_o,
  output logic                                     frame_end_o,
  // configuration writes
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [bin3_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [bin3_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int SumW  = SAMPLE_BITS + 2;
  localparam int LineW = 2 * SAMPLE_BITS;
  localparam int WidthResetLast =
    ((bin3_pkg::WidthReset < MAX_WIDTH) ? bin3_pkg::WidthReset : MAX_WIDTH) - 1;
  localparam int HeightResetLast = bin3_pkg::HeightReset - 1;

  // Frame size, kept as last column and last row
  logic [ColW-1:0]           w_last_q;
  logic [bin3_pkg::RowW-1:0] h_last_q;
  logic [31:0]               width_req, height_req;
  logic                      cfg_wr, cfg_hit;

  // Position of the next input item
  logic [ColW-1:0]           col_q;
  logic [bin3_pkg::RowW-1:0] row_q;
  logic                      in_acc;

  // Window stage
  logic                      s1_valid_q, s1_adv, s2_ready;
  logic [SAMPLE_BITS-1:0]    s1_sample_q;
  logic [ColW-1:0]           s1_col_q;
  logic [bin3_pkg::RowW-1:0] s1_row_q;
  bin3_pkg::bin3_flags_t     s1_flags_q, flags_d;
  logic [LineW-1:0]          line_rdata;
  logic [SAMPLE_BITS-1:0]    top0, mid0;
  logic [SumW-1:0]           vsum, vs_c2_q, vs_c1_q;
  logic [SAMPLE_BITS-1:0]    center_q;

  // Configuration: sizes saturate into range
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_wr && ((cfg_index_i == bin3_pkg::REG_IMAGE_WIDTH) ||
                                  (cfg_index_i == bin3_pkg::REG_IMAGE_HEIGHT));

  always_comb begin
    width_req  = 32'(cfg_wdata_i[bin3_pkg::WidthCfgW-1:0]);
    height_req = 32'(cfg_wdata_i[bin3_pkg::HeightCfgW-1:0]);
    if (width_req < 32'(bin3_pkg::MinSize)) begin
      width_req = 32'(bin3_pkg::MinSize);
    end
    if (width_req > 32'(MAX_WIDTH)) begin
      width_req = 32'(MAX_WIDTH);
    end
    if (height_req < 32'(bin3_pkg::MinSize)) begin
      height_req = 32'(bin3_pkg::MinSize);
    end
    if (height_req > 32'(bin3_pkg::MaxHeight)) begin
      height_req = 32'(bin3_pkg::MaxHeight);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= ColW'(WidthResetLast);
      h_last_q <= bin3_pkg::RowW'(HeightResetLast);
    end else if (cfg_wr) begin
      if (cfg_index_i == bin3_pkg::REG_IMAGE_WIDTH) begin
        w_last_q <= ColW'(width_req - 32'd1);
      end
      if (cfg_index_i == bin3_pkg::REG_IMAGE_HEIGHT) begin
        h_last_q <= bin3_pkg::RowW'(height_req - 32'd1);
      end
    end
  end

  // Raster position counters
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (col_q == w_last_q) begin
        col_q <= '0;
        row_q <= (row_q == h_last_q) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  always_comb begin
    flags_d.delayed  = (row_q != '0) && (col_q != '0);
    flags_d.border   = (row_q == bin3_pkg::RowW'(1)) || (col_q == ColW'(1));
    flags_d.last_col = (col_q == w_last_q);
    flags_d.last_row = (row_q == h_last_q);
  end

  // Window stage registers; line memory data lands here
  assign s1_adv = s1_valid_q && s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= sample_i;
      s1_col_q    <= col_q;
      s1_row_q    <= row_q;
      s1_flags_q  <= flags_d;
    end
  end

  // Line memory: read at acceptance, written back when the item moves on
  bin3_line_mem #(
    .DATA_W (LineW),
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (ColW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i ({mid0, s1_sample_q}),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  assign top0 = line_rdata[LineW-1:SAMPLE_BITS];
  assign mid0 = line_rdata[SAMPLE_BITS-1:0];

  // Vertical pass at the new column, weights 1,2,1
  assign vsum = SumW'(top0) + (SumW'(mid0) << 1) + SumW'(s1_sample_q);

  // Column sums of c-2 and c-1 and the raw center sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_c2_q  <= '0;
      vs_c1_q  <= '0;
      center_q <= '0;
    end else if (s1_adv) begin
      vs_c2_q  <= vs_c1_q;
      vs_c1_q  <= vsum;
      center_q <= mid0;
    end
  end

  bin3_emit #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COL_W       (ColW)
  ) u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bundle_valid_i (s1_valid_q),
    .bundle_ready_o (s2_ready),
    .flags_i        (s1_flags_q),
    .row_i          (s1_row_q),
    .col_i          (s1_col_q),
    .vsum_c2_i      (vs_c2_q),
    .vsum_c1_i      (vs_c1_q),
    .vsum_c0_i      (vsum),
    .center_i       (center_q),
    .mid_i          (mid0),
    .bot_i          (s1_sample_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .value_o        (value_o),
    .frame_end_o    (frame_end_o)
  );

  `BIN3_ASSERT(a_col_range, col_q <= w_last_q, "column counter past row end")
  `BIN3_ASSERT(a_row_range, row_q <= h_last_q, "row counter past frame end")
  `BIN3_ASSERT_NEXT(a_acc_fills_s1, in_acc, s1_valid_q, "accepted item lost before window stage")

endmodule

`default_nettype wire
